FILE: hdl/pcs_pkg.sv
`default_nettype none
package pcs_pkg;

  localparam int PCT_W = 14;
  localparam logic [PCT_W-1:0] PCT_RESET = 14'd5000;
  localparam int DIVISOR = 10000;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_PCT = 1'b0;

  localparam int QDEPTH = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUT,
    ST_MUL,
    ST_DIV,
    ST_RANK,
    ST_OUT
  } back_state_t;

endpackage
`default_nettype wire

FILE: hdl/pcs_ram.sv
`default_nettype none
module pcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/pcs_front.sv
`default_nettype none
module pcs_front #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                   in_last,
  output logic                        item_valid,
  input  wire logic                   item_ready,
  output logic      [SAMPLE_BITS-1:0] item_sample,
  output logic                        item_last
);
  import pcs_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  logic [SAMPLE_BITS-1:0] smp_q_r [QDEPTH];
  logic                   last_q_r [QDEPTH];
  logic [PW-1:0]          wr_ptr_r;
  logic [PW-1:0]          rd_ptr_r;
  logic [PW:0]            fill_r;
  logic                   push;
  logic                   pop;

  assign in_ready    = (fill_r != (PW+1)'(QDEPTH));
  assign item_valid  = (fill_r != '0);
  assign item_sample = smp_q_r[rd_ptr_r];
  assign item_last   = last_q_r[rd_ptr_r];
  assign push        = in_valid && in_ready;
  assign pop         = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      smp_q_r[wr_ptr_r]  <= in_sample;
      last_q_r[wr_ptr_r] <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/pcs_back.sv
`default_nettype none
module pcs_back #(
  parameter int SAMPLE_BITS = 32,
  parameter int MAX_SAMPLES = 256
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [pcs_pkg::PCT_W-1:0] pct,
  input  wire logic                     item_valid,
  output logic                          item_ready,
  input  wire logic [SAMPLE_BITS-1:0]   item_sample,
  input  wire logic                     item_last,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic      [SAMPLE_BITS-1:0]   out_percentile_value,
  output logic                          out_overflow
);
  import pcs_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int XW = PCT_W + CW;
  localparam int QW = XW - 13;
  localparam int RSH = XW + $clog2(DIVISOR);
  localparam int PRW = 2 * XW + 1;
  localparam logic [XW:0] RECIP =
    (XW+1)'(((64'd1 << RSH) + 64'(DIVISOR - 1)) / 64'(DIVISOR));

  back_state_t            state_r, state_nxt;
  logic [SAMPLE_BITS-1:0] smp_r, smp_nxt;
  logic                   last_r, last_nxt;
  logic [AW-1:0]          pos_r, pos_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [XW-1:0]          rem_r, rem_nxt;
  logic [QW-1:0]          quo_r, quo_nxt;
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_value_r;
  logic                   out_ovf_r;
  logic                   load_out;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [PRW-1:0]         prod;
  logic [CW-1:0]          n_minus1;

  pcs_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_SAMPLES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign prod     = PRW'(rem_r) * PRW'(RECIP);
  assign n_minus1 = count_r - 1'b1;

  always_comb begin
    state_nxt  = state_r;
    smp_nxt    = smp_r;
    last_nxt   = last_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    item_ready = 1'b0;
    load_out   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = pos_r;
    ram_wdata  = smp_r;
    ram_re     = 1'b0;
    ram_raddr  = pos_r - 1'b1;
    case (state_r)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          smp_nxt  = item_sample;
          last_nxt = item_last;
          if (count_r == CW'(MAX_SAMPLES)) begin
            ovf_nxt   = 1'b1;
            state_nxt = item_last ? ST_MUL : ST_IDLE;
          end else begin
            pos_nxt = count_r[AW-1:0];
            if (count_r == '0) begin
              state_nxt = ST_PUT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = count_r[AW-1:0] - 1'b1;
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if ($signed(ram_rdata) > $signed(smp_r)) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_nxt   = pos_r - 1'b1;
          if (pos_r == AW'(1)) begin
            state_nxt = ST_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = pos_r - AW'(2);
          end
        end else begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        count_nxt = count_r + 1'b1;
        state_nxt = last_r ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        rem_nxt   = XW'(pct) * XW'(count_r) + XW'(DIVISOR - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        quo_nxt   = prod[RSH +: QW];
        state_nxt = ST_RANK;
      end
      ST_RANK: begin
        ram_re = 1'b1;
        if (QW'(count_r) <= quo_r) begin
          ram_raddr = n_minus1[AW-1:0];
        end else begin
          ram_raddr = quo_r[AW-1:0];
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    smp_r  <= smp_nxt;
    last_r <= last_nxt;
    pos_r  <= pos_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    if (load_out) begin
      out_value_r <= ram_rdata;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_percentile_value = out_value_r;
  assign out_overflow         = out_ovf_r;

endmodule
`default_nettype wire

FILE: hdl/percentile_selector.sv
// Percentile selector. Samples of a set arrive on the in_ channel (valid/ready), the
// final one flagged by in_last. A small item queue feeds an insertion engine that keeps
// the samples in ascending order in a single-port-write, registered-read RAM.
// To store a sample the engine reads the stored samples from the top down, moves each
// one that is larger up by one entry, stops at the first one that is not larger, and
// then writes the new sample into the gap. The RAM write port moves one entry per cycle
// while shifting. The queue absorbs short bursts at one item per cycle until it is full.
// After the last item the rank ceil(p*N/10000) is formed in the multiply and divide
// states by one multiply and a reciprocal multiplication for the division, clamped to
// N-1, and the sample at that rank is read in the rank state and placed in the output
// register in the output state once that register is free.
// Samples beyond MAX_SAMPLES are dropped and flagged with out_overflow. If the receiver
// stalls, the result waits in the output register; the queue keeps taking items until it
// is full, then in_ready falls. The user must write the percentile register over the APB
// port only while the block is idle; the block does not enforce this. Reset (synchronous,
// rst_n low) empties the queue, clears the set and out_valid, sets the percentile to 50%.
`default_nettype none
module percentile_selector #(
  parameter int SAMPLE_BITS = 32,
  parameter int MAX_SAMPLES = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [SAMPLE_BITS-1:0]      in_sample,
  input  wire logic                        in_last,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [SAMPLE_BITS-1:0]      out_percentile_value,
  output logic                             out_overflow,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pcs_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [pcs_pkg::CFG_DW-1:0]  pwdata,
  output logic      [pcs_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready
);
  import pcs_pkg::*;

  logic [PCT_W-1:0]       pct_r;
  logic                   item_valid;
  logic                   item_ready;
  logic [SAMPLE_BITS-1:0] item_sample;
  logic                   item_last;
  logic                   reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_PCT);
  assign prdata  = reg_sel ? CFG_DW'(pct_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= PCT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      pct_r <= pwdata[PCT_W-1:0];
    end
  end

  pcs_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .in_last    (in_last),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_sample(item_sample),
    .item_last  (item_last)
  );

  pcs_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .pct                 (pct_r),
    .item_valid          (item_valid),
    .item_ready          (item_ready),
    .item_sample         (item_sample),
    .item_last           (item_last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_percentile_value(out_percentile_value),
    .out_overflow        (out_overflow)
  );

endmodule
`default_nettype wire

FILE: hdl/pcs_checker.sv
`default_nettype none
module pcs_checker #(
  parameter int SAMPLE_BITS = 32
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [SAMPLE_BITS-1:0]     out_percentile_value,
  input wire logic                       out_overflow,
  input wire logic                       psel,
  input wire logic                       penable,
  input wire logic                       pwrite,
  input wire logic [pcs_pkg::CFG_AW-1:0] paddr,
  input wire logic [pcs_pkg::CFG_DW-1:0] pwdata,
  input wire logic [pcs_pkg::CFG_DW-1:0] prdata,
  input wire logic                       pready
);
  import pcs_pkg::*;

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_percentile_value)
      && $stable(out_overflow))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A written percentile reads back.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && (paddr[2] == REG_PCT)
      |=> (paddr[2] != REG_PCT) || (prdata[PCT_W-1:0] == $past(pwdata[PCT_W-1:0])))
    else $error("percentile register did not read back");

  // A result needs an accepted item and its processing after reset.
  a_no_early_result: assert property (@(posedge clk)
    $rose(out_valid) |-> $past(rst_n, 1) && $past(rst_n, 2))
    else $error("result appeared too soon after reset");

  // The input queue accepts items right after reset.
  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind percentile_selector pcs_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_pcs_checker (.*);
`default_nettype wire
